// ===== sv/quaternion_to_euler_core_assert.svh =====
// Assertion macros used by the checker file of the quaternion to Euler core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef QUATERNION_TO_EULER_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define Q2E_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define Q2E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/q2e_pkg.sv =====
// Shared widths, payload types and the CORDIC arctangent table for the
// quaternion to Euler core. No dependencies.
`timescale 1ns / 1ps

package q2e_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;

    localparam int Q_W      = 16;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 34;
    localparam int CORDIC_W = 38;
    localparam int ANG_W    = 32;
    localparam int OUT_W    = 16;

    // Integer square root of a value no larger than 2^56: 29 digit steps.
    localparam int SQRT_STEPS = 29;
    localparam int ROOT_W     = 58;
    localparam int ROOT_OUT_W = 29;

    localparam logic signed [SUM_W-1:0] ONE_Q28     = 34'sd268435456;
    localparam logic signed [SUM_W-1:0] NEG_ONE_Q28 = -34'sd268435456;
    localparam logic signed [OUT_W-1:0] HALF_PI     = 16'sd16384;
    localparam logic signed [OUT_W-1:0] NEG_HALF_PI = -16'sd16384;
    localparam logic [ANG_W-1:0]        ANG_PI      = 32'h8000_0000;
    localparam logic [ANG_W-1:0]        ANG_ROUND   = 32'h0000_8000;

    typedef struct packed {
        logic signed [PROD_W-1:0] wx;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] wz;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] wy;
        logic signed [PROD_W-1:0] zx;
    } prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] ry;
        logic signed [SUM_W-1:0] rx;
        logic signed [SUM_W-1:0] yy;
        logic signed [SUM_W-1:0] yx;
        logic signed [SUM_W-1:0] s;
        logic                    sat_pos;
        logic                    sat_neg;
    } term_t;

    typedef struct packed {
        logic sat_pos;
        logic sat_neg;
    } lock_t;

    // atan(2^-i) with 2^31 standing for pi.
    function automatic logic [ANG_W-1:0] atan_entry(input int idx);
        logic [ANG_W-1:0] r;
        unique case (idx)
            0:       r = 32'h20000000;
            1:       r = 32'h12E4051E;
            2:       r = 32'h09FB385B;
            3:       r = 32'h051111D4;
            4:       r = 32'h028B0D43;
            5:       r = 32'h0145D7E1;
            6:       r = 32'h00A2F61E;
            7:       r = 32'h00517C55;
            8:       r = 32'h0028BE53;
            9:       r = 32'h00145F2F;
            10:      r = 32'h000A2F98;
            11:      r = 32'h000517CC;
            12:      r = 32'h00028BE6;
            13:      r = 32'h000145F3;
            14:      r = 32'h0000A2FA;
            15:      r = 32'h0000517D;
            16:      r = 32'h000028BE;
            17:      r = 32'h0000145F;
            18:      r = 32'h00000A30;
            19:      r = 32'h00000518;
            20:      r = 32'h0000028C;
            21:      r = 32'h00000146;
            22:      r = 32'h000000A3;
            23:      r = 32'h00000051;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/q2e_cordic.sv =====
// Pipelined vectoring CORDIC: one stage for the half-plane fold, one per
// iteration and one for rounding to a 16-bit binary angle. Uses q2e_pkg.
`timescale 1ns / 1ps

module q2e_cordic #(
    parameter int STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [q2e_pkg::SUM_W-1:0]    in_y,
    input  logic signed [q2e_pkg::SUM_W-1:0]    in_x,
    output logic signed [q2e_pkg::OUT_W-1:0]    angle
);

    localparam int CW = q2e_pkg::CORDIC_W;
    localparam int AW = q2e_pkg::ANG_W;
    localparam int SW = q2e_pkg::SUM_W;

    logic signed [CW-1:0] x_reg   [0:STEPS];
    logic signed [CW-1:0] y_reg   [0:STEPS];
    logic [AW-1:0]        acc_reg [0:STEPS];
    logic                 zero_reg[0:STEPS];
    logic [AW-1:0]        acc_rnd;
    logic signed [q2e_pkg::OUT_W-1:0] angle_reg;

    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;

    assign xe = {{(CW-SW){in_x[SW-1]}}, in_x};
    assign ye = {{(CW-SW){in_y[SW-1]}}, in_y};

    // A vector in the left half-plane is turned by pi first.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            if (in_x[SW-1])
            begin
                x_reg[0]   <= -xe;
                y_reg[0]   <= -ye;
                acc_reg[0] <= q2e_pkg::ANG_PI;
            end
            else
            begin
                x_reg[0]   <= xe;
                y_reg[0]   <= ye;
                acc_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][CW-1])
                begin
                    x_reg[i+1]   <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] - (x_reg[i] >>> i);
                    acc_reg[i+1] <= acc_reg[i] + q2e_pkg::atan_entry(i);
                end
                else
                begin
                    x_reg[i+1]   <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] + (x_reg[i] >>> i);
                    acc_reg[i+1] <= acc_reg[i] - q2e_pkg::atan_entry(i);
                end
            end
        end
    end

    assign acc_rnd = acc_reg[STEPS] + q2e_pkg::ANG_ROUND;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= zero_reg[STEPS] ? '0 : signed'(acc_rnd[AW-1:AW-q2e_pkg::OUT_W]);
        end
    end

    assign angle = angle_reg;

endmodule

// ===== sv/quaternion_to_euler_core.sv =====
// Top level of the quaternion to Euler angle converter (ZYX order).
// Depends on q2e_pkg and q2e_cordic.
`timescale 1ns / 1ps

// Usage:
// A request on the input channel carries one quaternion (quat_x, quat_y,
// quat_z, quat_w) in signed Q1.14. It is taken on a clock edge where in_valid
// is high and in_stall is low. The output channel presents roll, pitch and yaw
// as 16-bit binary angles (32768 is pi) plus a gimbal-lock flag, and hands a
// result over on an edge where out_valid is high and out_stall is low.
// The pipeline runs through the products, the sums, the saturation flags with
// the squared sine, the square-root start value, 29 square-root digit stages
// for the pitch cosine, then the CORDIC stages. Throughput is one request per cycle while no result is stalled.
// When the receiver stalls a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits; the data path needs no reset.

module quaternion_to_euler_core #(
    parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [q2e_pkg::Q_W-1:0]     quat_x,
    input  logic signed [q2e_pkg::Q_W-1:0]     quat_y,
    input  logic signed [q2e_pkg::Q_W-1:0]     quat_z,
    input  logic signed [q2e_pkg::Q_W-1:0]     quat_w,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [q2e_pkg::OUT_W-1:0]   roll_angle,
    output logic signed [q2e_pkg::OUT_W-1:0]   pitch_angle,
    output logic signed [q2e_pkg::OUT_W-1:0]   yaw_angle,
    output logic                               gimbal_lock
);

    localparam int SQ  = q2e_pkg::SQRT_STEPS;
    localparam int RW  = q2e_pkg::ROOT_W;
    localparam int SW  = q2e_pkg::SUM_W;
    localparam int PW  = q2e_pkg::PROD_W;
    localparam int LAT = SQ + 4 + CORDIC_STEPS + 2;
    localparam logic [RW-1:0] N_TOP = RW'(1) << (2 * (SQ - 1));

    logic              adv;
    logic [LAT-1:0]    vld_reg;
    logic [LAT-1:0]    vld_next;

    q2e_pkg::prod_t    prod_reg;
    q2e_pkg::term_t    term_next;
    q2e_pkg::term_t    term_sat;
    q2e_pkg::term_t    term_reg [0:SQ+2];
    logic signed [q2e_pkg::ROOT_OUT_W-1:0] s_low;
    logic signed [2*q2e_pkg::ROOT_OUT_W-1:0] sq_full;
    logic [RW-1:0]     sq_reg;
    logic [RW-1:0]     n_reg    [0:SQ];
    logic [RW-1:0]     root_reg [0:SQ];
    q2e_pkg::lock_t    lock_reg [0:CORDIC_STEPS+1];
    logic signed [SW-1:0] cos_pitch;
    logic signed [q2e_pkg::OUT_W-1:0] roll_cd;
    logic signed [q2e_pkg::OUT_W-1:0] pitch_cd;
    logic signed [q2e_pkg::OUT_W-1:0] yaw_cd;

    function automatic logic signed [SW-1:0] sx(input logic [PW-1:0] v);
        return {{(SW-PW){v[PW-1]}}, v};
    endfunction

    // A stalled result freezes every stage at once.
    assign in_stall  = vld_reg[LAT-1] & out_stall;
    assign adv       = ~in_stall;
    assign out_valid = vld_reg[LAT-1];
    assign vld_next  = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg.wx <= quat_w * quat_x;
            prod_reg.yz <= quat_y * quat_z;
            prod_reg.xx <= quat_x * quat_x;
            prod_reg.yy <= quat_y * quat_y;
            prod_reg.wz <= quat_w * quat_z;
            prod_reg.xy <= quat_x * quat_y;
            prod_reg.zz <= quat_z * quat_z;
            prod_reg.wy <= quat_w * quat_y;
            prod_reg.zx <= quat_z * quat_x;
        end
    end

    always_comb
    begin
        term_next.ry      = (sx(prod_reg.wx) + sx(prod_reg.yz)) <<< 1;
        term_next.rx      = q2e_pkg::ONE_Q28 - ((sx(prod_reg.xx) + sx(prod_reg.yy)) <<< 1);
        term_next.yy      = (sx(prod_reg.wz) + sx(prod_reg.xy)) <<< 1;
        term_next.yx      = q2e_pkg::ONE_Q28 - ((sx(prod_reg.yy) + sx(prod_reg.zz)) <<< 1);
        term_next.s       = (sx(prod_reg.wy) - sx(prod_reg.zx)) <<< 1;
        term_next.sat_pos = 1'b0;
        term_next.sat_neg = 1'b0;
    end

    always_comb
    begin
        term_sat         = term_reg[0];
        term_sat.sat_pos = term_reg[0].s >= q2e_pkg::ONE_Q28;
        term_sat.sat_neg = term_reg[0].s <= q2e_pkg::NEG_ONE_Q28;
    end

    // Below saturation the pitch sine fits in 29 signed bits.
    assign s_low   = term_reg[0].s[q2e_pkg::ROOT_OUT_W-1:0];
    assign sq_full = s_low * s_low;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            term_reg[0]         <= term_next;
            term_reg[1]         <= term_sat;
            sq_reg              <= RW'(sq_full);
            term_reg[2]         <= term_reg[1];
            n_reg[0]            <= N_TOP - sq_reg;
            root_reg[0]         <= '0;
        end
    end

    // Cosine of pitch: one square-root digit per stage.
    for (genvar j = 0; j < SQ; j++) begin : g_sqrt
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQ - 1 - j));
        logic [RW-1:0] trial;

        assign trial = root_reg[j] + BIT;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                term_reg[j+3] <= term_reg[j+2];
                if (n_reg[j] >= trial)
                begin
                    n_reg[j+1]    <= n_reg[j] - trial;
                    root_reg[j+1] <= (root_reg[j] >> 1) + BIT;
                end
                else
                begin
                    n_reg[j+1]    <= n_reg[j];
                    root_reg[j+1] <= root_reg[j] >> 1;
                end
            end
        end
    end

    assign cos_pitch = {{(SW-q2e_pkg::ROOT_OUT_W){1'b0}},
                        root_reg[SQ][q2e_pkg::ROOT_OUT_W-1:0]};

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .clk   (clk),
        .en    (adv),
        .in_y  (term_reg[SQ+2].ry),
        .in_x  (term_reg[SQ+2].rx),
        .angle (roll_cd)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .clk   (clk),
        .en    (adv),
        .in_y  (term_reg[SQ+2].s),
        .in_x  (cos_pitch),
        .angle (pitch_cd)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .clk   (clk),
        .en    (adv),
        .in_y  (term_reg[SQ+2].yy),
        .in_x  (term_reg[SQ+2].yx),
        .angle (yaw_cd)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lock_reg[0].sat_pos <= term_reg[SQ+2].sat_pos;
            lock_reg[0].sat_neg <= term_reg[SQ+2].sat_neg;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS + 1; k++) begin : g_lock
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lock_reg[k+1] <= lock_reg[k];
            end
        end
    end

    always_comb
    begin
        priority if (lock_reg[CORDIC_STEPS+1].sat_pos)
        begin
            pitch_angle = q2e_pkg::HALF_PI;
        end
        else if (lock_reg[CORDIC_STEPS+1].sat_neg)
        begin
            pitch_angle = q2e_pkg::NEG_HALF_PI;
        end
        else
        begin
            pitch_angle = pitch_cd;
        end
    end

    assign roll_angle  = roll_cd;
    assign yaw_angle   = yaw_cd;
    assign gimbal_lock = lock_reg[CORDIC_STEPS+1].sat_pos | lock_reg[CORDIC_STEPS+1].sat_neg;

endmodule

// ===== sv/q2e_checker.sv =====
// Port-level checks for the quaternion to Euler core, bound to the top level.
// Depends on quaternion_to_euler_core_assert.svh.
`timescale 1ns / 1ps
`include "quaternion_to_euler_core_assert.svh"

module q2e_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] roll_angle,
    input logic [15:0] pitch_angle,
    input logic [15:0] yaw_angle,
    input logic        gimbal_lock
);

    // A waiting result stays offered.
    `Q2E_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

    `Q2E_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(roll_angle) && $stable(pitch_angle) && $stable(yaw_angle) && $stable(gimbal_lock),
        "stalled result changed")

    // The input side only waits because a result is held up.
    `Q2E_ASSERT_NOW(a_backpressure, in_stall, out_valid && out_stall, "input stalled without cause")

    // A locked pitch sits exactly at plus or minus a quarter turn.
    `Q2E_ASSERT_NOW(a_lock_pitch, out_valid && gimbal_lock,
        (pitch_angle == 16'h4000) || (pitch_angle == 16'hC000), "locked pitch not saturated")

endmodule

bind quaternion_to_euler_core q2e_checker u_q2e_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle),
    .gimbal_lock (gimbal_lock)
);

// ===== sim/quaternion_to_euler_core_tb.sv =====
// Self-checking testbench for quaternion_to_euler_core: random and directed quaternions,
// random input gaps and output stalls, results checked against a built-in angle predictor.
// Depends on q2e_pkg and the core RTL.
`timescale 1ns / 1ps

module quaternion_to_euler_core_tb;

    localparam int STEPS = q2e_pkg::CORDIC_STEPS_DEF;
    localparam int LATENCY = STEPS + 35;

    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } quat_t;

    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic        lock;
    } euler_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] quat_x = '0;
    logic signed [15:0] quat_y = '0;
    logic signed [15:0] quat_z = '0;
    logic signed [15:0] quat_w = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic gimbal_lock;

    quat_t  pending_quats[$];
    euler_t expected_angles[$];
    int     mismatches = 0;
    bit     stimulus_done = 1'b0;
    int     hold_off = 0;
    bit     drain_pause = 1'b0;
    int     accepted = 0;
    int     gap = 0;
    bit     in_taken = 1'b0;

    quaternion_to_euler_core #(.CORDIC_STEPS(STEPS)) i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .out_valid(out_valid), .out_stall(out_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .gimbal_lock(gimbal_lock)
    );

    always #1 clk = ~clk;

    function automatic void add_quat(quat_t q);
        pending_quats = {pending_quats, q};
    endfunction

    function automatic logic [15:0] vector_angle(longint y, longint x);
        logic [31:0] acc;
        longint xs;
        longint ys;
        acc = '0;
        if (x == 0 && y == 0)
        begin
            return 16'd0;
        end
        if (x < 0)
        begin
            x = -x;
            y = -y;
            acc = q2e_pkg::ANG_PI;
        end
        for (int i = 0; i < STEPS && i < q2e_pkg::CORDIC_STEPS_MAX; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys;
                y -= xs;
                acc += q2e_pkg::atan_entry(i);
            end
            else
            begin
                x -= ys;
                y += xs;
                acc -= q2e_pkg::atan_entry(i);
            end
        end
        acc = acc + q2e_pkg::ANG_ROUND;
        return acc[31:16];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
            begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic euler_t quat_to_euler(quat_t q);
        euler_t r;
        longint x, y, z, w, s;
        longint unsigned c;
        x = q.qx;
        y = q.qy;
        z = q.qz;
        w = q.qw;
        s = 2 * (w * y - z * x);
        r.roll = vector_angle(2 * (w * x + y * z), (64'sd1 << 28) - 2 * (x * x + y * y));
        r.yaw = vector_angle(2 * (w * z + x * y), (64'sd1 << 28) - 2 * (y * y + z * z));
        if (s >= (64'sd1 << 28))
        begin
            r.pitch = q2e_pkg::HALF_PI;
            r.lock = 1'b1;
        end
        else if (s <= -(64'sd1 << 28))
        begin
            r.pitch = q2e_pkg::NEG_HALF_PI;
            r.lock = 1'b1;
        end
        else
        begin
            c = int_sqrt((64'd1 << 56) - longint'(s * s));
            r.pitch = vector_angle(s, longint'(c));
            r.lock = 1'b0;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 40)
        begin
            return 0;
        end
        if ($urandom_range(0, 99) < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic quat_t unit_quat();
        quat_t q;
        real a, b, c, d, n;
        a = $itor($signed($urandom_range(0, 2000)) - 1000);
        b = $itor($signed($urandom_range(0, 2000)) - 1000);
        c = $itor($signed($urandom_range(0, 2000)) - 1000);
        d = $itor($signed($urandom_range(0, 2000)) - 1000);
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n == 0.0)
        begin
            n = 1.0;
            d = 1.0;
        end
        q.qx = 16'($rtoi(a / n * 16384.0));
        q.qy = 16'($rtoi(b / n * 16384.0));
        q.qz = 16'($rtoi(c / n * 16384.0));
        q.qw = 16'($rtoi(d / n * 16384.0));
        return q;
    endfunction

    // Directed cases, then mostly unit quaternions with some raw bit patterns.
    initial
    begin
        quat_t q;
        add_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
        add_quat('{16'sd0, 16'sd0, 16'sd0, -16'sd16384});
        add_quat('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
        add_quat('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
        add_quat('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
        add_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        // Pitch sine just beyond plus and minus one, on the gimbal-lock side.
        add_quat('{16'sd0, 16'sd11585, 16'sd0, 16'sd11586});
        add_quat('{16'sd0, -16'sd11585, 16'sd0, 16'sd11586});
        add_quat('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
        add_quat('{-16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
        add_quat('{16'sd0, 16'sd11584, 16'sd0, 16'sd11585});
        add_quat('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        add_quat('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
        add_quat('{16'sh8000, 16'sd32767, -16'sd1, 16'sd1});
        add_quat('{16'sd1, 16'sd0, 16'sd0, -16'sd16384});
        add_quat('{-16'sd1, 16'sd0, -16'sd1, -16'sd16384});
        for (int n = 0; n < 650; n++)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                q = unit_quat();
            end
            else
            begin
                q = {$urandom, $urandom};
            end
            add_quat(q);
        end
    end

    // Request driver: changes inputs on the falling edge only.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (in_taken)
            begin
                accepted++;
                if (accepted == 200)
                begin
                    drain_pause <= 1'b1;
                end
            end
            if (drain_pause && expected_angles.size() == 0 && !out_valid)
            begin
                drain_pause <= 1'b0;
            end
            if (gap > 0)
            begin
                gap <= gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_quats.size() == 0 || (drain_pause && accepted >= 200))
            begin
                in_valid <= 1'b0;
                if (pending_quats.size() == 0)
                begin
                    stimulus_done <= 1'b1;
                end
            end
            else
            begin
                {quat_x, quat_y, quat_z, quat_w} <= pending_quats.pop_front();
                in_valid <= 1'b1;
                gap <= (accepted < 20 || (accepted > 300 && accepted < 400)) ? 0 : pick_gap();
            end
        end
    end

    // Receiver stall, with one long hold-off while requests keep coming.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (accepted == 320 && hold_off == 0)
            begin
                hold_off <= -200;
            end
            if (hold_off < 0)
            begin
                hold_off <= (hold_off == -1) ? 1 : hold_off + 1;
                out_stall <= 1'b1;
            end
            else if (accepted < 20 || (accepted > 420 && accepted < 500))
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= (pick_gap() > 1);
            end
        end
    end

    always @(posedge clk)
    begin
        euler_t exp_r;
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
        begin
            expected_angles = {expected_angles,
                               quat_to_euler({quat_x, quat_y, quat_z, quat_w})};
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_angles.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected result roll %0d pitch %0d yaw %0d lock %0b",
                         $time, roll_angle, pitch_angle, yaw_angle, gimbal_lock);
            end
            else
            begin
                exp_r = expected_angles.pop_front();
                if (roll_angle !== exp_r.roll)
                begin
                    mismatches++;
                    $display("%0t roll expected %0d actual %0d", $time,
                             $signed(exp_r.roll), roll_angle);
                end
                if (pitch_angle !== exp_r.pitch)
                begin
                    mismatches++;
                    $display("%0t pitch expected %0d actual %0d", $time,
                             $signed(exp_r.pitch), pitch_angle);
                end
                if (yaw_angle !== exp_r.yaw)
                begin
                    mismatches++;
                    $display("%0t yaw expected %0d actual %0d", $time,
                             $signed(exp_r.yaw), yaw_angle);
                end
                if (gimbal_lock !== exp_r.lock)
                begin
                    mismatches++;
                    $display("%0t gimbal_lock expected %0b actual %0b", $time,
                             exp_r.lock, gimbal_lock);
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (stimulus_done && expected_angles.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin
        #200000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== quaternion_to_euler_core.f =====
+incdir+sv
sv/q2e_pkg.sv
sv/q2e_cordic.sv
sv/quaternion_to_euler_core.sv
sv/q2e_checker.sv
sim/quaternion_to_euler_core_tb.sv
